FILE: design/packed_pattern_unpacker_macros.svh
// assertion macros shared by the packed pattern unpacker modules
// depends on nothing; taken in by `include where assertions are written
`ifndef PACKED_PATTERN_UNPACKER_MACROS_SVH
`define PACKED_PATTERN_UNPACKER_MACROS_SVH

// plain clocked check with reset disable
`define PPU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check with reset disable
`define PPU_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

FILE: design/ppu_pkg.sv
// package of the packed pattern unpacker: types, codes and constants
// depends on nothing; used by every module of the block
`default_nettype none

package ppu_pkg;

    // width store depth and address width
    localparam int MAX_CHANNELS = 256;
    localparam int CHAN_ADDR_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // display widths per field
    localparam logic [3:0] NOTE_COLS  = 4'd2;
    localparam logic [3:0] INSTR_COLS = NOTE_COLS + 4'd3;
    localparam logic [3:0] EFF1_COLS  = INSTR_COLS + 4'd5;
    localparam logic [3:0] EFF2_COLS  = EFF1_COLS + 4'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT     = 2'd1;
    localparam logic [1:0] CFG_PACKED_SIZE   = 2'd2;

    // result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // end status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRAILING = 2'd1;
    localparam logic [1:0] ST_OVERRUN  = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    // field codes
    localparam logic [2:0] FLD_NOTE   = 3'd0;
    localparam logic [2:0] FLD_INSTR  = 3'd1;
    localparam logic [2:0] FLD_EFF1   = 3'd2;
    localparam logic [2:0] FLD_PARAM1 = 3'd3;
    localparam logic [2:0] FLD_EFF2   = 3'd4;
    localparam logic [2:0] FLD_PARAM2 = 3'd5;

    typedef enum logic [2:0] {
        PH_START,
        PH_CHAN,
        PH_FLAGS,
        PH_FIELD,
        PH_DROP
    } phase_t;

    typedef struct packed {
        logic [7:0]  channel_count;
        logic [15:0] row_count;
        logic [31:0] packed_size;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] row_index;
        logic [7:0]  channel_index;
        logic [2:0]  field_code;
        logic [7:0]  field_value;
        logic [3:0]  column_width;
        logic [1:0]  status;
        logic [31:0] extra_bytes;
        logic        last;
    } result_t;

    typedef struct packed {
        logic                   clear;
        logic                   rd_en;
        logic [CHAN_ADDR_W-1:0] rd_addr;
        logic                   wr_en;
        logic [CHAN_ADDR_W-1:0] wr_addr;
        logic [3:0]             wr_data;
    } ram_req_t;

    // minimum display width implied by a field
    function automatic logic [3:0] width_for_field(input logic [2:0] code);
        logic [3:0] w;
        case (code)
            FLD_NOTE:   w = NOTE_COLS;
            FLD_INSTR:  w = INSTR_COLS;
            FLD_EFF1:   w = EFF1_COLS;
            FLD_PARAM1: w = EFF1_COLS;
            FLD_EFF2:   w = EFF2_COLS;
            FLD_PARAM2: w = EFF2_COLS;
            default:    w = EFF2_COLS;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/packed_pattern_unpacker.sv
// top level of the packed pattern unpacker: config registers and wiring
// depends on ppu_pkg, ppu_width_ram, ppu_parser and ppu_out_fifo
`default_nettype none

// Takes one packed pattern byte per cycle while in_ready is high and gives
// field writes and an end report per pattern. The parser state and the
// 256 x 4 channel width ram (registered read, issued on the channel byte and
// used from the flags byte on) never stall the input. A byte that ends an
// entry and the pattern together gives two results, and the output side then
// gives them one at a time: in_ready is low while fewer than two of the
// four result queue slots are free, so a held output stalls input after two
// to three bytes that give results. Width store clearing at each pattern
// start is done by dropping all per-channel valid bits at once, so there is
// no clearing pass. Configuration writes are always ready and are registered.
module packed_pattern_unpacker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [15:0]      row_index,
    output logic [7:0]       channel_index,
    output logic [2:0]       field_code,
    output logic [7:0]       field_value,
    output logic [3:0]       column_width,
    output logic [1:0]       status,
    output logic [31:0]      extra_bytes,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    ppu_pkg::cfg_t     cfg_reg;
    ppu_pkg::ram_req_t ram_req;
    ppu_pkg::result_t  res0, res1, head;
    logic [3:0]        rd_width;
    logic [1:0]        push_cnt;
    logic              room;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign accept    = in_valid && room;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= 8'd4;
            cfg_reg.row_count     <= 16'd64;
            cfg_reg.packed_size   <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ppu_pkg::CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[7:0];
                ppu_pkg::CFG_ROW_COUNT:     cfg_reg.row_count     <= cfg_data[15:0];
                ppu_pkg::CFG_PACKED_SIZE:   cfg_reg.packed_size   <= cfg_data;
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    ppu_width_ram u_width_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rd_width (rd_width)
    );

    ppu_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .data_byte (data_byte),
        .rd_width  (rd_width),
        .ram_req   (ram_req),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    ppu_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // result item fields
    assign kind          = head.kind;
    assign row_index     = head.row_index;
    assign channel_index = head.channel_index;
    assign field_code    = head.field_code;
    assign field_value   = head.field_value;
    assign column_width  = head.column_width;
    assign status        = head.status;
    assign extra_bytes   = head.extra_bytes;
    assign last          = head.last;

endmodule

`default_nettype wire

FILE: design/ppu_width_ram.sv
// per-channel display width store: synchronous ram with registered read
// depends on ppu_pkg; valid bits give the cleared value after a pattern start
`default_nettype none

module ppu_width_ram (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ppu_pkg::ram_req_t req,
    output logic [3:0]            rd_width
);

    logic [3:0]                      mem [ppu_pkg::MAX_CHANNELS];
    logic [ppu_pkg::MAX_CHANNELS-1:0] valid_reg;
    logic [3:0]                      rd_data_reg;
    logic                            rd_valid_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // entry valid bits, all dropped at once on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= req.clear ? 1'b0 : valid_reg[req.rd_addr];
            end
        end
    end

    // entry never written since the clear reads as zero
    assign rd_width = rd_valid_reg ? rd_data_reg : 4'd0;

endmodule

`default_nettype wire

FILE: design/ppu_out_fifo.sv
// result queue taking up to two results per cycle and giving one while out_ready is high
// depends on ppu_pkg
`default_nettype none
`include "packed_pattern_unpacker_macros.svh"

module ppu_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [1:0]      push_cnt,
    input  wire ppu_pkg::result_t res0,
    input  wire ppu_pkg::result_t res1,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ppu_pkg::result_t     head
);

    ppu_pkg::result_t                entry_reg [ppu_pkg::FIFO_DEPTH];
    logic [ppu_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ppu_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ppu_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [ppu_pkg::FIFO_PTR_W-1:0] wr_ptr_inc;
    logic                            pop;

    assign out_valid  = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= ppu_pkg::FIFO_CNT_W'(ppu_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + ppu_pkg::FIFO_PTR_W'(1);

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ppu_pkg::FIFO_PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + ppu_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + ppu_pkg::FIFO_CNT_W'(push_cnt)
                      - ppu_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // each slot takes the first or the second result of the cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ppu_pkg::FIFO_DEPTH; i++)
        begin
            if (push_cnt != 2'd0 && wr_ptr_reg == ppu_pkg::FIFO_PTR_W'(i))
            begin
                entry_reg[i] <= res0;
            end
            else if (push_cnt == 2'd2 && wr_ptr_inc == ppu_pkg::FIFO_PTR_W'(i))
            begin
                entry_reg[i] <= res1;
            end
        end
    end

    `PPU_ASSERT(a_count_bound, clk, rst_n, count_reg <= ppu_pkg::FIFO_CNT_W'(ppu_pkg::FIFO_DEPTH), "result queue count beyond depth")
    `PPU_ASSERT_IMPL(a_push_room, clk, rst_n, push_cnt != 2'd0, room, "results pushed without room")

endmodule

`default_nettype wire

FILE: design/ppu_parser.sv
// byte parser of the packed pattern: phase, row, budget and channel tracking
// depends on ppu_pkg; drives the width ram and the result queue
`default_nettype none
`include "packed_pattern_unpacker_macros.svh"

module ppu_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ppu_pkg::cfg_t   cfg,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic [3:0]      rd_width,
    output ppu_pkg::ram_req_t    ram_req,
    output logic [1:0]           push_cnt,
    output ppu_pkg::result_t     res0,
    output ppu_pkg::result_t     res1
);

    ppu_pkg::phase_t phase_reg, phase_next;
    ppu_pkg::phase_t work;
    logic [15:0]     row_reg, row_next;
    logic [32:0]     bl_reg, bl_next;
    logic [7:0]      chan_reg, chan_next;
    logic [5:0]      flags_reg, flags_next;
    logic [3:0]      cur_w_reg, cur_w_next;

    logic            start, empty_start;
    logic [32:0]     eff_bl, bl_dec, bl_neg;
    logic [15:0]     eff_row, row_inc, chk_row;
    logic            dec_pos, dec_neg, end_hit;
    logic [1:0]      end_status;
    logic [31:0]     end_extra;
    ppu_pkg::phase_t end_phase;
    logic [2:0]      code;
    logic [5:0]      flags_clr;
    logic [3:0]      need_w, new_w;
    logic            chan_bad;
    ppu_pkg::result_t wr_res, end_res;

    // budget and row seen by this byte
    assign start       = (phase_reg == ppu_pkg::PH_START);
    assign empty_start = (cfg.packed_size == 32'd0) || (cfg.row_count == 16'd0)
                         || (cfg.channel_count == 8'd0);
    assign eff_bl      = start ? {1'b0, cfg.packed_size} : bl_reg;
    assign eff_row     = start ? 16'd0 : row_reg;
    assign bl_dec      = eff_bl - 33'd1;
    assign bl_neg      = ~eff_bl + 33'd2;
    assign dec_neg     = bl_dec[32];
    assign dec_pos     = !bl_dec[32] && (bl_dec != 33'd0);
    assign row_inc     = eff_row + 16'd1;
    assign chan_bad    = (chan_reg >= cfg.channel_count)
                         || ({1'b0, chan_reg} >= 9'(ppu_pkg::MAX_CHANNELS));

    // end check at an entry boundary; only a row byte advances the row
    always_comb
    begin
        chk_row = ((start || phase_reg == ppu_pkg::PH_CHAN) && (data_byte == 8'd0))
                  ? row_inc : eff_row;
        end_hit = !(dec_pos && (chk_row < cfg.row_count) && (cfg.channel_count != 8'd0));
        if (dec_neg)
        begin
            end_status = ppu_pkg::ST_OVERRUN;
            end_extra  = bl_neg[31:0];
            end_phase  = ppu_pkg::PH_START;
        end
        else if (dec_pos)
        begin
            end_status = ppu_pkg::ST_TRAILING;
            end_extra  = bl_dec[31:0];
            end_phase  = ppu_pkg::PH_DROP;
        end
        else
        begin
            end_status = ppu_pkg::ST_OK;
            end_extra  = 32'd0;
            end_phase  = ppu_pkg::PH_START;
        end
    end

    // lowest pending field and the grown width
    always_comb
    begin
        code = ppu_pkg::FLD_PARAM2;
        for (int i = 5; i >= 0; i--)
        begin
            if (flags_reg[i])
            begin
                code = 3'(i);
            end
        end
        flags_clr = flags_reg & ~(6'd1 << code);
        need_w    = ppu_pkg::width_for_field(code);
        new_w     = (cur_w_reg < need_w) ? need_w : cur_w_reg;
    end

    // field write result
    always_comb
    begin
        wr_res               = '0;
        wr_res.kind          = ppu_pkg::KIND_WRITE;
        wr_res.row_index     = row_reg;
        wr_res.channel_index = chan_reg;
        wr_res.field_code    = code;
        wr_res.field_value   = data_byte;
        wr_res.column_width  = new_w;
    end

    // phase sequencing and results
    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        bl_next    = bl_reg;
        chan_next  = chan_reg;
        flags_next = flags_reg;
        cur_w_next = cur_w_reg;
        push_cnt   = 2'd0;
        res1       = '0;
        end_res             = '0;
        end_res.kind        = ppu_pkg::KIND_END;
        end_res.status      = end_status;
        end_res.extra_bytes = end_extra;
        end_res.last        = 1'b1;
        res0       = end_res;
        work       = start ? ppu_pkg::PH_CHAN : phase_reg;
        ram_req         = '0;
        ram_req.clear   = accept && start;
        ram_req.rd_addr = ppu_pkg::CHAN_ADDR_W'(data_byte - 8'd1);
        ram_req.wr_addr = ppu_pkg::CHAN_ADDR_W'(chan_reg);
        ram_req.wr_data = new_w;

        if (start)
        begin
            row_next   = 16'd0;
            chan_next  = 8'd0;
            flags_next = 6'd0;
        end

        if (accept)
        begin
            if (start && empty_start)
            begin
                // nothing to parse: report at once, rest of budget dropped
                push_cnt = 2'd1;
                if (cfg.packed_size != 32'd0 && cfg.row_count != 16'd0)
                begin
                    res0.status      = ppu_pkg::ST_TRAILING;
                    res0.extra_bytes = cfg.packed_size;
                end
                else
                begin
                    res0.status      = ppu_pkg::ST_OK;
                    res0.extra_bytes = 32'd0;
                end
                bl_next    = (cfg.packed_size == 32'd0) ? 33'd0 : bl_dec;
                phase_next = dec_pos ? ppu_pkg::PH_DROP : ppu_pkg::PH_START;
            end
            else
            begin
                bl_next = bl_dec;
                case (work)
                    ppu_pkg::PH_CHAN:
                    begin
                        if (data_byte == 8'd0)
                        begin
                            row_next   = row_inc;
                            phase_next = ppu_pkg::PH_CHAN;
                            if (end_hit)
                            begin
                                push_cnt   = 2'd1;
                                phase_next = end_phase;
                            end
                        end
                        else
                        begin
                            chan_next     = data_byte - 8'd1;
                            phase_next    = ppu_pkg::PH_FLAGS;
                            ram_req.rd_en = 1'b1;
                        end
                    end
                    ppu_pkg::PH_FLAGS:
                    begin
                        if (chan_bad)
                        begin
                            push_cnt         = 2'd1;
                            res0.status      = ppu_pkg::ST_INVALID;
                            res0.extra_bytes = dec_pos ? bl_dec[31:0] : 32'd0;
                            phase_next       = dec_pos ? ppu_pkg::PH_DROP
                                                       : ppu_pkg::PH_START;
                        end
                        else
                        begin
                            flags_next = data_byte[5:0];
                            cur_w_next = rd_width;
                            if (data_byte[5:0] == 6'd0)
                            begin
                                phase_next = ppu_pkg::PH_CHAN;
                                if (end_hit)
                                begin
                                    push_cnt   = 2'd1;
                                    phase_next = end_phase;
                                end
                            end
                            else
                            begin
                                phase_next = ppu_pkg::PH_FIELD;
                            end
                        end
                    end
                    ppu_pkg::PH_FIELD:
                    begin
                        flags_next    = flags_clr;
                        cur_w_next    = new_w;
                        ram_req.wr_en = 1'b1;
                        res0          = wr_res;
                        res0.last     = 1'b1;
                        push_cnt      = 2'd1;
                        if (flags_clr == 6'd0)
                        begin
                            phase_next = ppu_pkg::PH_CHAN;
                            if (end_hit)
                            begin
                                res0.last  = 1'b0;
                                res1       = end_res;
                                push_cnt   = 2'd2;
                                phase_next = end_phase;
                            end
                        end
                    end
                    ppu_pkg::PH_DROP:
                    begin
                        if (!dec_pos)
                        begin
                            phase_next = ppu_pkg::PH_START;
                        end
                    end
                    default:
                    begin
                        phase_next = ppu_pkg::PH_START;
                    end
                endcase
            end
        end
        else
        begin
            // hold everything while no item arrives
            row_next   = row_reg;
            chan_next  = chan_reg;
            flags_next = flags_reg;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ppu_pkg::PH_START;
            row_reg   <= 16'd0;
            bl_reg    <= 33'd0;
            chan_reg  <= 8'd0;
            flags_reg <= 6'd0;
            cur_w_reg <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            bl_reg    <= bl_next;
            chan_reg  <= chan_next;
            flags_reg <= flags_next;
            cur_w_reg <= cur_w_next;
        end
    end

    `PPU_ASSERT_IMPL(a_field_flags, clk, rst_n, phase_reg == ppu_pkg::PH_FIELD, flags_reg != 6'd0, "field phase with no pending flags")
    `PPU_ASSERT_IMPL(a_drop_budget, clk, rst_n, phase_reg == ppu_pkg::PH_DROP, !bl_reg[32] && bl_reg != 33'd0, "drop phase with no budget left")
    `PPU_ASSERT_IMPL(a_pair_order, clk, rst_n, push_cnt == 2'd2, res0.kind == ppu_pkg::KIND_WRITE && res1.kind == ppu_pkg::KIND_END && ram_req.wr_en, "result pair out of order")

endmodule

`default_nettype wire
